### hw/rtl/tcs_pkg.sv
// Shared types, codes and default sizes for the tree contrast sum block.
// Used by every module under hw/rtl except tcs_ram; depends on nothing else.
package tcs_pkg;

    localparam int IDX_W          = 10;
    localparam int VAL_W          = 32;
    localparam int TOTAL_W        = 48;
    localparam int NODE_COUNT_DEF = 1024;
    localparam int EDGE_COUNT_DEF = 1024;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic [1:0] {
        OP_LOAD_TIP  = 2'd0,
        OP_LOAD_EDGE = 2'd1,
        OP_COMBINE   = 2'd2,
        OP_CLEAR     = 2'd3
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] load_index;
        logic [VAL_W-1:0] load_value;
        logic [IDX_W-1:0] parent_node;
        logic [IDX_W-1:0] child_first;
        logic [IDX_W-1:0] child_second;
        logic [IDX_W-1:0] edge_first;
        logic [IDX_W-1:0] edge_second;
        logic [IDX_W-1:0] up_edge;
        logic             has_up_edge;
    } t_item;

    typedef enum logic [2:0] {
        S_IDLE, S_RD0, S_RD1, S_RD2, S_CHK, S_CALC, S_RES
    } t_back_state;

    typedef enum logic [1:0] {
        A_IDLE, A_MUL, A_DIV, A_DONE
    } t_arith_state;

    typedef struct packed {
        logic             start;
        logic [VAL_W:0]   mag;
        logic [VAL_W-1:0] b0;
        logic [VAL_W-1:0] b1;
    } t_arith_req;

    typedef struct packed {
        logic             done;
        logic [VAL_W:0]   step;
        logic [VAL_W-1:0] adj;
    } t_arith_rsp;

endpackage

### hw/rtl/tcs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module tcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/tcs_front.sv
// Front end: accepts words, decodes the opcode and holds them in a short queue.
// Depends on tcs_pkg.
module tcs_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [1:0]    i_opcode,
    input  tcs_pkg::t_item i_fields,
    output logic          o_head_valid,
    output tcs_pkg::t_item o_head,
    input  logic          i_pop
);

    tcs_pkg::t_item r_q [tcs_pkg::QUEUE_DEPTH];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic           push;
    tcs_pkg::t_item decoded;

    always_comb begin
        decoded    = i_fields;
        decoded.op = tcs_pkg::t_op'(i_opcode);
    end

    assign o_in_ready   = (r_count != 2'(tcs_pkg::QUEUE_DEPTH));
    assign push         = i_in_valid && o_in_ready;
    assign o_head_valid = (r_count != 2'd0);
    assign o_head       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= decoded;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(push) - 2'(i_pop);
        end
    end

endmodule

### hw/rtl/tcs_arith.sv
// Shift-add multipliers and restoring dividers for the weighted mean step and
// the edge adjustment. Depends on tcs_pkg.
module tcs_arith (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tcs_pkg::t_arith_req i_req,
    output tcs_pkg::t_arith_rsp o_rsp
);

    localparam int W = tcs_pkg::VAL_W;

    tcs_pkg::t_arith_state r_state, n_state;
    logic [W:0]     r_m;
    logic [W-1:0]   r_b0;
    logic [W-1:0]   r_b1;
    logic [W:0]     r_den;
    logic [2*W:0]   r_p1, r_p2;
    logic [W:0]     r_r1, r_r2;
    logic [6:0]     r_cnt;
    logic [W+1:0]   div1, div2;

    // One restoring step: returns {quotient bit, new remainder}.
    function automatic logic [W+1:0] div_step(input logic [W:0] rem, input logic nb,
                                              input logic [W:0] den);
        logic [W+1:0] sh;
        logic [W+1:0] diff;
        sh   = {rem, nb};
        diff = sh - {1'b0, den};
        if (sh >= {1'b0, den}) begin
            div_step = {1'b1, diff[W:0]};
        end else begin
            div_step = {1'b0, sh[W:0]};
        end
    endfunction

    assign div1 = div_step(r_r1, r_p1[2*W], r_den);
    assign div2 = div_step(r_r2, r_p2[2*W], r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcs_pkg::A_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tcs_pkg::A_IDLE: if (i_req.start) n_state = tcs_pkg::A_MUL;
            tcs_pkg::A_MUL:  if (r_cnt == 7'(W - 1)) n_state = tcs_pkg::A_DIV;
            tcs_pkg::A_DIV:  if (r_cnt == 7'(2 * W)) n_state = tcs_pkg::A_DONE;
            default:         n_state = tcs_pkg::A_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            tcs_pkg::A_IDLE: begin
                r_m   <= i_req.mag;
                r_b0  <= i_req.b0;
                r_b1  <= i_req.b1;
                r_den <= {1'b0, i_req.b0} + {1'b0, i_req.b1};
                r_p1  <= '0;
                r_p2  <= '0;
                r_r1  <= '0;
                r_r2  <= '0;
                r_cnt <= '0;
            end
            tcs_pkg::A_MUL: begin
                // Both products take their multiplier bits from b0, MSB first.
                r_p1 <= {r_p1[2*W-1:0], 1'b0} + (r_b0[W-1] ? (2*W+1)'(r_m) : '0);
                r_p2 <= {r_p2[2*W-1:0], 1'b0} + (r_b0[W-1] ? (2*W+1)'(r_b1) : '0);
                r_b0 <= {r_b0[W-2:0], 1'b0};
                r_cnt <= (r_cnt == 7'(W - 1)) ? 7'd0 : r_cnt + 7'd1;
            end
            tcs_pkg::A_DIV: begin
                r_r1  <= div1[W:0];
                r_r2  <= div2[W:0];
                r_p1  <= {r_p1[2*W-1:0], div1[W+1]};
                r_p2  <= {r_p2[2*W-1:0], div2[W+1]};
                r_cnt <= r_cnt + 7'd1;
            end
            default: begin
            end
        endcase
    end

    assign o_rsp.done = (r_state == tcs_pkg::A_DONE);
    assign o_rsp.step = r_p1[W:0];
    assign o_rsp.adj  = r_p2[W-1:0];

endmodule

### hw/rtl/tcs_back.sv
// Back end: sequences store reads, arithmetic and write-back for each word,
// and holds the result register. Depends on tcs_pkg, tcs_ram and tcs_arith.
module tcs_back #(
    parameter int NODE_COUNT = tcs_pkg::NODE_COUNT_DEF,
    parameter int EDGE_COUNT = tcs_pkg::EDGE_COUNT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_head_valid,
    input  tcs_pkg::t_item i_head,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [tcs_pkg::TOTAL_W-1:0] o_contrast_total,
    output logic           o_length_error
);

    localparam int W   = tcs_pkg::VAL_W;
    localparam int TW  = tcs_pkg::TOTAL_W;
    localparam int NAW = $clog2(NODE_COUNT);
    localparam int EAW = $clog2(EDGE_COUNT);

    tcs_pkg::t_back_state r_state, n_state;
    tcs_pkg::t_item r_item;
    logic [W-1:0]  r_v0, r_v1, r_b0, r_b1, r_eup;
    logic [W:0]    r_mag;
    logic          r_neg;
    logic [TW-1:0] r_total;
    logic          r_err;
    logic          r_out_valid;
    logic [TW-1:0] r_out_total;
    logic          r_out_err;

    logic           node_we, edge_we;
    logic [NAW-1:0] node_waddr, node_raddr;
    logic [EAW-1:0] edge_waddr, edge_raddr;
    logic [W-1:0]   node_wdata, edge_wdata, node_rdata, edge_rdata;
    tcs_pkg::t_arith_req req;
    tcs_pkg::t_arith_rsp rsp;
    logic [W:0]     diff, mean;
    logic [TW:0]    total_sum;
    logic [W:0]     adj_sum;
    logic           zero_len;

    function automatic logic node_ok(input logic [tcs_pkg::IDX_W-1:0] idx);
        node_ok = (32'(idx) < 32'(NODE_COUNT));
    endfunction

    function automatic logic edge_ok(input logic [tcs_pkg::IDX_W-1:0] idx);
        edge_ok = (32'(idx) < 32'(EDGE_COUNT));
    endfunction

    tcs_ram #(.WIDTH(W), .DEPTH(NODE_COUNT)) u_node_ram (
        .i_clk(i_clk), .i_we(node_we), .i_waddr(node_waddr), .i_wdata(node_wdata),
        .i_raddr(node_raddr), .o_rdata(node_rdata)
    );

    tcs_ram #(.WIDTH(W), .DEPTH(EDGE_COUNT)) u_edge_ram (
        .i_clk(i_clk), .i_we(edge_we), .i_waddr(edge_waddr), .i_wdata(edge_wdata),
        .i_raddr(edge_raddr), .o_rdata(edge_rdata)
    );

    tcs_arith u_arith (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req), .o_rsp(rsp));

    assign diff      = {r_v1[W-1], r_v1} - {r_v0[W-1], r_v0};
    assign mean      = r_neg ? ({r_v0[W-1], r_v0} - rsp.step)
                             : ({r_v0[W-1], r_v0} + rsp.step);
    assign total_sum = {1'b0, r_total} + (TW+1)'(r_mag);
    assign adj_sum   = {1'b0, rsp.adj} + {1'b0, r_eup};
    assign zero_len  = (r_b0 == '0) || (r_b1 == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_pop      = 1'b0;
        node_we    = 1'b0;
        edge_we    = 1'b0;
        node_waddr = NAW'(i_head.load_index);
        edge_waddr = EAW'(i_head.load_index);
        node_wdata = i_head.load_value;
        edge_wdata = i_head.load_value;
        node_raddr = NAW'(r_item.child_first);
        edge_raddr = EAW'(r_item.edge_first);
        req.start  = 1'b0;
        req.mag    = diff[W] ? (~diff + 1'b1) : diff;
        req.b0     = r_b0;
        req.b1     = r_b1;
        unique case (r_state)
            tcs_pkg::S_IDLE: begin
                if (i_head_valid && (i_head.op == tcs_pkg::OP_LOAD_TIP
                        || i_head.op == tcs_pkg::OP_LOAD_EDGE || !r_out_valid)) begin
                    o_pop = 1'b1;
                    case (i_head.op)
                        tcs_pkg::OP_LOAD_TIP:  node_we = node_ok(i_head.load_index);
                        tcs_pkg::OP_LOAD_EDGE: edge_we = edge_ok(i_head.load_index);
                        tcs_pkg::OP_COMBINE:   n_state = tcs_pkg::S_RD0;
                        default:               n_state = tcs_pkg::S_IDLE;
                    endcase
                end
            end
            tcs_pkg::S_RD0: n_state = tcs_pkg::S_RD1;
            tcs_pkg::S_RD1: begin
                node_raddr = NAW'(r_item.child_second);
                edge_raddr = EAW'(r_item.edge_second);
                n_state    = tcs_pkg::S_RD2;
            end
            tcs_pkg::S_RD2: begin
                edge_raddr = EAW'(r_item.up_edge);
                n_state    = tcs_pkg::S_CHK;
            end
            tcs_pkg::S_CHK: begin
                req.start = !zero_len;
                n_state   = zero_len ? tcs_pkg::S_RES : tcs_pkg::S_CALC;
            end
            tcs_pkg::S_CALC: begin
                node_waddr = NAW'(r_item.parent_node);
                edge_waddr = EAW'(r_item.up_edge);
                node_wdata = mean[W-1:0];
                edge_wdata = adj_sum[W] ? '1 : adj_sum[W-1:0];
                if (rsp.done) begin
                    node_we = node_ok(r_item.parent_node);
                    edge_we = r_item.has_up_edge && edge_ok(r_item.up_edge);
                    n_state = tcs_pkg::S_RES;
                end
            end
            default: n_state = tcs_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            tcs_pkg::S_IDLE: if (o_pop) r_item <= i_head;
            tcs_pkg::S_RD1: begin
                r_v0 <= node_ok(r_item.child_first) ? node_rdata : '0;
                r_b0 <= edge_ok(r_item.edge_first) ? edge_rdata : '0;
            end
            tcs_pkg::S_RD2: begin
                r_v1 <= node_ok(r_item.child_second) ? node_rdata : '0;
                r_b1 <= edge_ok(r_item.edge_second) ? edge_rdata : '0;
            end
            tcs_pkg::S_CHK: begin
                r_eup <= edge_rdata;
                r_mag <= req.mag;
                r_neg <= diff[W];
            end
            default: begin
            end
        endcase
        if (!i_rst_n) begin
            r_total     <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_total <= '0;
            r_out_err   <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop && i_head.op == tcs_pkg::OP_CLEAR) begin
                r_total     <= '0;
                r_err       <= 1'b0;
                r_out_valid <= 1'b1;
                r_out_total <= '0;
                r_out_err   <= 1'b0;
            end
            if (r_state == tcs_pkg::S_CHK && zero_len) begin
                r_err <= 1'b1;
            end
            if (r_state == tcs_pkg::S_CALC && rsp.done) begin
                r_total <= total_sum[TW] ? '1 : total_sum[TW-1:0];
            end
            if (r_state == tcs_pkg::S_RES) begin
                r_out_valid <= 1'b1;
                r_out_total <= r_total;
                r_out_err   <= r_err;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_contrast_total = r_out_total;
    assign o_length_error   = r_out_err;

    a_done_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp.done |-> r_state == tcs_pkg::S_CALC)
        else $error("arithmetic finished outside the wait state");

    a_write_slots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (node_we || edge_we) |-> (r_state == tcs_pkg::S_IDLE || r_state == tcs_pkg::S_CALC))
        else $error("store written during the read sequence");

    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_head.op == tcs_pkg::OP_CLEAR)
        |=> (r_out_valid && r_out_total == '0 && !r_out_err))
        else $error("clear did not present a zero result");

endmodule

### hw/rtl/tree_contrast_sum.sv
// Tree contrast sum: a word enters the queue while it has room; a load or a clear is handled
// in the back end's idle state, while a combine occupies the back end for 3 store reads,
// a length check, 32 multiply steps, 65 divide steps, a finish step, write-back and result
// load. Loads flow at one per cycle while the back end is idle; a combine or clear waits
// for the result register to empty. Reset is synchronous, active low: it zeroes the total
// and error flag and empties the queue; stores are not cleared.
module tree_contrast_sum #(
    parameter int NODE_COUNT = tcs_pkg::NODE_COUNT_DEF,
    parameter int EDGE_COUNT = tcs_pkg::EDGE_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [9:0]  i_load_index,
    input  logic signed [31:0] i_load_value,
    input  logic [9:0]  i_parent_node,
    input  logic [9:0]  i_child_first,
    input  logic [9:0]  i_child_second,
    input  logic [9:0]  i_edge_first,
    input  logic [9:0]  i_edge_second,
    input  logic [9:0]  i_up_edge,
    input  logic        i_has_up_edge,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [47:0] o_contrast_total,
    output logic        o_length_error
);

    // The incoming word is packed into one struct; the front end fills in the
    // decoded operation and queues it, so a word can be accepted while the
    // back end is still busy with a long combine.
    tcs_pkg::t_item fields;
    tcs_pkg::t_item head;
    logic           head_valid;
    logic           pop;

    always_comb begin
        fields.op           = tcs_pkg::OP_CLEAR;
        fields.load_index   = i_load_index;
        fields.load_value   = i_load_value;
        fields.parent_node  = i_parent_node;
        fields.child_first  = i_child_first;
        fields.child_second = i_child_second;
        fields.edge_first   = i_edge_first;
        fields.edge_second  = i_edge_second;
        fields.up_edge      = i_up_edge;
        fields.has_up_edge  = i_has_up_edge;
    end

    tcs_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_opcode(i_opcode), .i_fields(fields),
        .o_head_valid(head_valid), .o_head(head), .i_pop(pop)
    );

    // The back end owns both stores and the result register; it only takes a
    // combine or clear word when the result register is free.
    tcs_back #(.NODE_COUNT(NODE_COUNT), .EDGE_COUNT(EDGE_COUNT)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_head_valid(head_valid), .i_head(head), .o_pop(pop),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_contrast_total(o_contrast_total), .o_length_error(o_length_error)
    );

endmodule
